// File: src/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros used by the checker file
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is held
`define ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked assertion that also holds across reset
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: src/pol_pkg.sv
// ---------------------------------------------------------------------------
// pol_pkg
// Shared constants, codes and types of the positional ordered list.
// ---------------------------------------------------------------------------
`default_nettype none

package pol_pkg;

    // List size and derived widths
    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // Field widths
    localparam int FUNC_W   = 3;
    localparam int POS_W    = 5;
    localparam int VAL_W    = 32;
    localparam int STAT_W   = 2;
    localparam int LEN_W    = 5;

    // Input tdata layout
    localparam int S_FUNC_LSB = 0;
    localparam int S_POS_LSB  = S_FUNC_LSB + FUNC_W;
    localparam int S_VAL_LSB  = S_POS_LSB + POS_W;
    localparam int S_USED_W   = S_VAL_LSB + VAL_W;
    localparam int S_DATA_W   = ((S_USED_W + 7) / 8) * 8;

    // Output tdata layout
    localparam int M_STAT_LSB = 0;
    localparam int M_VAL_LSB  = M_STAT_LSB + STAT_W;
    localparam int M_LEN_LSB  = M_VAL_LSB + VAL_W;
    localparam int M_USED_W   = M_LEN_LSB + LEN_W;
    localparam int M_DATA_W   = ((M_USED_W + 7) / 8) * 8;
    localparam int M_PAD_W    = M_DATA_W - M_USED_W;

    // Operation codes
    localparam logic [FUNC_W-1:0] F_PUSH     = 3'd0;
    localparam logic [FUNC_W-1:0] F_APPEND   = 3'd1;
    localparam logic [FUNC_W-1:0] F_INSERT   = 3'd2;
    localparam logic [FUNC_W-1:0] F_DEL_HEAD = 3'd3;
    localparam logic [FUNC_W-1:0] F_DEL_TAIL = 3'd4;
    localparam logic [FUNC_W-1:0] F_DEL_POS  = 3'd5;
    localparam logic [FUNC_W-1:0] F_READ     = 3'd6;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd3;

    // Controller to datapath commands
    typedef struct packed {
        logic             exec;     // run the accepted item, load its first result
        logic             rd_step;  // load the next read-out entry
        logic [IDX_W-1:0] rd_idx;   // entry to read out
        logic             rd_last;  // entry is the final one
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic [CNT_W-1:0] count;    // entries held now
        logic             multi;    // offered item is a read out of several entries
    } stat_t;

endpackage

`default_nettype wire

// File: src/pol_datapath.sv
// ---------------------------------------------------------------------------
// pol_datapath
// Shifting cell row, entry count, operation decode and result register.
// ---------------------------------------------------------------------------
`default_nettype none

module pol_datapath (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic [pol_pkg::S_DATA_W-1:0] s_tdata,
    input  wire pol_pkg::cmd_t                cmd,
    output pol_pkg::stat_t                    stat,
    output logic      [pol_pkg::M_DATA_W-1:0] m_tdata,
    output logic                              m_tlast
);

    logic [pol_pkg::VAL_W-1:0]    cells_reg [pol_pkg::CAPACITY];
    logic [pol_pkg::VAL_W-1:0]    cells_next [pol_pkg::CAPACITY];
    logic [pol_pkg::CNT_W-1:0]    count_reg, count_next;
    logic [pol_pkg::M_DATA_W-1:0] tdata_reg, tdata_next;
    logic                         tlast_reg, tlast_next;

    logic [pol_pkg::FUNC_W-1:0]   func;
    logic [pol_pkg::POS_W-1:0]    pos;
    logic [pol_pkg::VAL_W-1:0]    val;
    logic                         empty, full, in_range;
    logic                         ins_en, del_en, rd_en;
    logic [pol_pkg::IDX_W-1:0]    ins_pos, del_pos, rd_addr;
    logic [pol_pkg::STAT_W-1:0]   res_stat;
    logic [pol_pkg::VAL_W-1:0]    rd_data;

    // Unpack the offered item
    assign func = s_tdata[pol_pkg::S_FUNC_LSB +: pol_pkg::FUNC_W];
    assign pos  = s_tdata[pol_pkg::S_POS_LSB  +: pol_pkg::POS_W];
    assign val  = s_tdata[pol_pkg::S_VAL_LSB  +: pol_pkg::VAL_W];

    assign empty    = (count_reg == '0);
    assign full     = (int'(count_reg) >= pol_pkg::CAPACITY);
    assign in_range = (pos != '0) && (int'(pos) < int'(count_reg));

    // Status towards the controller
    assign stat.count = count_reg;
    assign stat.multi = (func == pol_pkg::F_READ) && (int'(count_reg) > 1);

    // Decode the operation: where to open or close a gap, and what to report
    always_comb begin
        ins_en   = 1'b0;
        del_en   = 1'b0;
        rd_en    = 1'b0;
        ins_pos  = '0;
        del_pos  = '0;
        res_stat = pol_pkg::ST_OK;
        unique case (func)
            pol_pkg::F_PUSH: begin
                if (full) res_stat = pol_pkg::ST_FULL;
                else      ins_en   = 1'b1;
            end
            pol_pkg::F_APPEND: begin
                ins_pos = pol_pkg::IDX_W'(count_reg);
                if (full) res_stat = pol_pkg::ST_FULL;
                else      ins_en   = 1'b1;
            end
            pol_pkg::F_INSERT: begin
                ins_pos = pol_pkg::IDX_W'(pos);
                priority if (empty)     res_stat = pol_pkg::ST_EMPTY;
                else if (!in_range)     res_stat = pol_pkg::ST_RANGE;
                else if (full)          res_stat = pol_pkg::ST_FULL;
                else                    ins_en   = 1'b1;
            end
            pol_pkg::F_DEL_HEAD: begin
                if (empty) res_stat = pol_pkg::ST_EMPTY;
                else       del_en   = 1'b1;
            end
            pol_pkg::F_DEL_TAIL: begin
                del_pos = pol_pkg::IDX_W'(count_reg - pol_pkg::CNT_W'(1));
                if (empty) res_stat = pol_pkg::ST_EMPTY;
                else       del_en   = 1'b1;
            end
            pol_pkg::F_DEL_POS: begin
                del_pos = pol_pkg::IDX_W'(pos);
                priority if (empty)     res_stat = pol_pkg::ST_EMPTY;
                else if (!in_range)     res_stat = pol_pkg::ST_RANGE;
                else                    del_en   = 1'b1;
            end
            pol_pkg::F_READ: begin
                if (empty) res_stat = pol_pkg::ST_EMPTY;
                else       rd_en    = 1'b1;
            end
            default: begin
                res_stat = pol_pkg::ST_OK;
            end
        endcase
    end

    // Single read port: removed entry or first entry on execute, else read-out index
    assign rd_addr = cmd.exec ? del_pos : cmd.rd_idx;
    assign rd_data = cells_reg[rd_addr];

    // Shift the cells in parallel to open or close a gap
    always_comb begin
        cells_next = cells_reg;
        count_next = count_reg;
        if (cmd.exec && ins_en) begin
            for (int i = 1; i < pol_pkg::CAPACITY; i++) begin
                if (pol_pkg::IDX_W'(i) > ins_pos) cells_next[i] = cells_reg[i-1];
            end
            cells_next[ins_pos] = val;
            count_next = count_reg + pol_pkg::CNT_W'(1);
        end
        if (cmd.exec && del_en) begin
            for (int i = 0; i < pol_pkg::CAPACITY - 1; i++) begin
                if (pol_pkg::IDX_W'(i) >= del_pos) cells_next[i] = cells_reg[i+1];
            end
            count_next = count_reg - pol_pkg::CNT_W'(1);
        end
    end

    // Build the next result
    always_comb begin
        tdata_next = tdata_reg;
        tlast_next = tlast_reg;
        if (cmd.exec) begin
            tdata_next = {{pol_pkg::M_PAD_W{1'b0}}, pol_pkg::LEN_W'(count_next),
                          (del_en || rd_en) ? rd_data : {pol_pkg::VAL_W{1'b0}}, res_stat};
            tlast_next = !(rd_en && (int'(count_reg) > 1));
        end else if (cmd.rd_step) begin
            tdata_next = {{pol_pkg::M_PAD_W{1'b0}}, pol_pkg::LEN_W'(count_reg),
                          rd_data, pol_pkg::ST_OK};
            tlast_next = cmd.rd_last;
        end
    end

    // Hold the count under reset; cells and result need none
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        cells_reg <= cells_next;
        tdata_reg <= tdata_next;
        tlast_reg <= tlast_next;
    end

    assign m_tdata = tdata_reg;
    assign m_tlast = tlast_reg;

endmodule

`default_nettype wire

// File: src/pol_ctrl.sv
// ---------------------------------------------------------------------------
// pol_ctrl
// Handshake control: accept items, step through a read out, own m_tvalid.
// ---------------------------------------------------------------------------
`default_nettype none

module pol_ctrl (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  wire logic           m_tready,
    input  wire pol_pkg::stat_t stat,
    output pol_pkg::cmd_t       cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_READ = 2'b10
    } state_t;

    state_t                    state_reg, state_next;
    logic [pol_pkg::IDX_W-1:0] idx_reg, idx_next;
    logic                      valid_reg, valid_next;
    logic                      out_free;

    // Result slot is free when empty or being taken this cycle
    assign out_free = !valid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE) && out_free;
    assign m_tvalid = valid_reg;

    // Sequence one item, or the entries of a read out one per cycle while the result slot is free
    always_comb begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        valid_next   = valid_reg && !m_tready;
        cmd.exec     = 1'b0;
        cmd.rd_step  = 1'b0;
        cmd.rd_idx   = idx_reg;
        cmd.rd_last  = (pol_pkg::CNT_W'(idx_reg) + pol_pkg::CNT_W'(1) == stat.count);
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid && s_tready) begin
                    cmd.exec   = 1'b1;
                    valid_next = 1'b1;
                    if (stat.multi) begin
                        state_next = S_READ;
                        idx_next   = pol_pkg::IDX_W'(1);
                    end
                end
            end
            S_READ: begin
                if (out_free) begin
                    cmd.rd_step = 1'b1;
                    valid_next  = 1'b1;
                    idx_next    = idx_reg + pol_pkg::IDX_W'(1);
                    if (cmd.rd_last) state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

endmodule

`default_nettype wire

// File: src/positional_ordered_list_unit.sv
// ---------------------------------------------------------------------------
// positional_ordered_list_unit
// Ordered list of signed 32-bit values with positional insert and delete.
// ---------------------------------------------------------------------------
// Each transfer on the s_ side runs one operation; push, append, insert and
// the three deletes complete in the cycle they are accepted, since all cells
// shift in parallel, and give one result. A read out gives one result per
// entry, one per cycle while results are being taken, so it occupies the
// block while the single output register is stepped through the cells; no
// new item is taken until its last entry is loaded. The output register lets
// the next item be accepted in the cycle its predecessor's result is taken,
// so with m_tready held high the rate is one item per cycle for updates.
// Results with a non-zero status always carry tlast.
// ---------------------------------------------------------------------------
`default_nettype none

module positional_ordered_list_unit (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    // tdata: func[2:0], position[7:3], item_value[39:8]
    input  wire logic [pol_pkg::S_DATA_W-1:0] s_tdata,
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    // tdata: status[1:0], result_value[33:2], list_length[38:34], zero[39]
    output logic      [pol_pkg::M_DATA_W-1:0] m_tdata,
    output logic                              m_tlast,
    output logic                              m_tvalid,
    input  wire logic                         m_tready
);

    pol_pkg::cmd_t  cmd;
    pol_pkg::stat_t stat;

    // Handshake and sequencing
    pol_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Cell row and result register
    pol_datapath u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tdata (s_tdata),
        .cmd     (cmd),
        .stat    (stat),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

endmodule

`default_nettype wire

// File: src/pol_checker.sv
// ---------------------------------------------------------------------------
// pol_checker
// Port-level checks of the positional ordered list, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module pol_checker (
    input wire logic                         aclk,
    input wire logic                         aresetn,
    input wire logic                         s_tready,
    input wire logic [pol_pkg::M_DATA_W-1:0] m_tdata,
    input wire logic                         m_tlast,
    input wire logic                         m_tvalid,
    input wire logic                         m_tready
);

    logic [pol_pkg::STAT_W-1:0] m_stat;
    logic [pol_pkg::LEN_W-1:0]  m_len;

    assign m_stat = m_tdata[pol_pkg::M_STAT_LSB +: pol_pkg::STAT_W];
    assign m_len  = m_tdata[pol_pkg::M_LEN_LSB +: pol_pkg::LEN_W];

    // Stalled result holds
    `ASSERT_CLK(a_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled result changed")

    // Length never exceeds the capacity
    `ASSERT_CLK(a_len, aclk, aresetn, m_tvalid |-> int'(m_len) <= pol_pkg::CAPACITY, "list length above capacity")

    // A refused or failed operation gives a single result
    `ASSERT_CLK(a_err_last, aclk, aresetn, m_tvalid && (m_stat != pol_pkg::ST_OK) |-> m_tlast, "error result without tlast")

    // No new item is taken while a read out is still pending
    `ASSERT_CLK(a_read_busy, aclk, aresetn, m_tvalid && !m_tlast |-> !s_tready, "item accepted during read out")

    // Output is idle straight after reset
    `ASSERT_ALWAYS(a_rst, aclk, !aresetn |=> !m_tvalid, "result valid after reset")

endmodule

bind positional_ordered_list_unit pol_checker u_pol_checker (.*);

`default_nettype wire

// File: bench/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for positional_ordered_list_unit. A shadow copy of
// the list predicts every result of each accepted s_ transfer. The results
// are queued and compared field by field with the m_ transfers. A short
// directed part covers the empty list, the full list, position bounds,
// extreme values and the longest read out. Random operations then run
// under three idle profiles and one long output stall.
// ---------------------------------------------------------------------------

module tb;

    // Spare operation code with no package name
    localparam logic [pol_pkg::FUNC_W-1:0] F_SPARE = 3'd7;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 20;

    typedef struct packed {
        logic [pol_pkg::STAT_W-1:0] status;
        logic [pol_pkg::VAL_W-1:0]  value;
        logic [pol_pkg::LEN_W-1:0]  length;
        logic                       last;
    } list_result_t;

    logic                           aclk = 1'b0;
    logic                           aresetn = 1'b0;
    logic [pol_pkg::S_DATA_W-1:0]   s_tdata = '0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [pol_pkg::M_DATA_W-1:0]   m_tdata;
    logic                           m_tlast;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;

    // Shadow copy of the list
    logic [pol_pkg::VAL_W-1:0]      shadow_cells [pol_pkg::CAPACITY];
    int                             shadow_len = 0;
    list_result_t                   expected_results [$];

    int                             send_idle_pct = 0;
    int                             recv_idle_pct = 0;
    int                             hold_left = 0;
    int                             cycle_count = 0;
    int                             errors = 0;
    int                             items_sent = 0;
    int                             results_checked = 0;
    int                             full_refusals = 0;
    int                             range_reports = 0;

    list_result_t                   want;
    logic [pol_pkg::STAT_W-1:0]     got_status;
    logic [pol_pkg::VAL_W-1:0]      got_value;
    logic [pol_pkg::LEN_W-1:0]      got_length;

    positional_ordered_list_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Queue one expected result
    task automatic queue_result(input logic [pol_pkg::STAT_W-1:0] st,
                                input logic [pol_pkg::VAL_W-1:0] v,
                                input logic last);
        list_result_t r;
        r.status = st;
        r.value  = v;
        r.length = pol_pkg::LEN_W'(shadow_len);
        r.last   = last;
        if (st == pol_pkg::ST_FULL) full_refusals++;
        if (st == pol_pkg::ST_RANGE) range_reports++;
        expected_results.push_back(r);
    endtask

    // Apply one operation to the shadow list and queue what it gives
    task automatic apply_list_op(input logic [pol_pkg::FUNC_W-1:0] func,
                                 input logic [pol_pkg::POS_W-1:0] pos,
                                 input logic [pol_pkg::VAL_W-1:0] val);
        logic [pol_pkg::STAT_W-1:0] st;
        logic [pol_pkg::VAL_W-1:0]  removed;
        logic                       pos_ok;
        int                         p;
        st = pol_pkg::ST_OK;
        removed = '0;
        p = int'(pos);
        pos_ok = (p >= 1) && (p < shadow_len);
        if (func == pol_pkg::F_DEL_HEAD) p = 0;
        if (func == pol_pkg::F_DEL_TAIL) p = shadow_len - 1;
        case (func)
            pol_pkg::F_PUSH, pol_pkg::F_APPEND: begin
                if (shadow_len >= pol_pkg::CAPACITY) begin
                    st = pol_pkg::ST_FULL;
                end else begin
                    p = (func == pol_pkg::F_PUSH) ? 0 : shadow_len;
                    for (int i = shadow_len; i > p; i--) shadow_cells[i] = shadow_cells[i-1];
                    shadow_cells[p] = val;
                    shadow_len++;
                end
            end
            pol_pkg::F_INSERT: begin
                if (shadow_len == 0) st = pol_pkg::ST_EMPTY;
                else if (!pos_ok) st = pol_pkg::ST_RANGE;
                else if (shadow_len >= pol_pkg::CAPACITY) st = pol_pkg::ST_FULL;
                else begin
                    for (int i = shadow_len; i > p; i--) shadow_cells[i] = shadow_cells[i-1];
                    shadow_cells[p] = val;
                    shadow_len++;
                end
            end
            pol_pkg::F_DEL_HEAD, pol_pkg::F_DEL_TAIL, pol_pkg::F_DEL_POS: begin
                if (shadow_len == 0) st = pol_pkg::ST_EMPTY;
                else if (func == pol_pkg::F_DEL_POS && !pos_ok) st = pol_pkg::ST_RANGE;
                else begin
                    removed = shadow_cells[p];
                    for (int i = p; i + 1 < shadow_len; i++) shadow_cells[i] = shadow_cells[i+1];
                    shadow_len--;
                end
            end
            pol_pkg::F_READ: begin
                if (shadow_len == 0) begin
                    st = pol_pkg::ST_EMPTY;
                end else begin
                    for (int i = 0; i < shadow_len; i++) begin
                        queue_result(pol_pkg::ST_OK, shadow_cells[i], i + 1 == shadow_len);
                    end
                    return;
                end
            end
            default: begin
            end
        endcase
        queue_result(st, removed, 1'b1);
    endtask

    // Offer one item, hold it until transferred, then predict its results
    task automatic send_item(input logic [pol_pkg::FUNC_W-1:0] func,
                             input logic [pol_pkg::POS_W-1:0] pos,
                             input logic [pol_pkg::VAL_W-1:0] val);
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {val, pos, func};
        do @(posedge aclk); while (!s_tready);
        items_sent++;
        apply_list_op(func, pos, val);
    endtask

    // Every operation that fails on an empty list, and the spare code
    task automatic test_empty_list();
        send_item(pol_pkg::F_READ, 5'd0, 32'h0);
        send_item(pol_pkg::F_DEL_HEAD, 5'd0, 32'h0);
        send_item(pol_pkg::F_DEL_TAIL, 5'd0, 32'h0);
        send_item(pol_pkg::F_DEL_POS, 5'd1, 32'h0);
        send_item(pol_pkg::F_INSERT, 5'd1, 32'h1234_5678);
        send_item(F_SPARE, 5'd31, 32'hFFFF_FFFF);
    endtask

    // Fill to capacity by push, append and insert with extreme values
    task automatic test_fill_to_capacity();
        send_item(pol_pkg::F_PUSH, 5'd0, 32'h8000_0000);
        send_item(pol_pkg::F_APPEND, 5'd31, 32'h7FFF_FFFF);
        send_item(pol_pkg::F_INSERT, 5'd1, 32'hFFFF_FFFF);
        send_item(pol_pkg::F_INSERT, 5'd2, 32'h0000_0000);
        while (shadow_len < pol_pkg::CAPACITY) begin
            case ($urandom_range(2))
                0: send_item(pol_pkg::F_PUSH, pol_pkg::POS_W'($urandom), $urandom);
                1: send_item(pol_pkg::F_APPEND, pol_pkg::POS_W'($urandom), $urandom);
                default: send_item(pol_pkg::F_INSERT,
                                   pol_pkg::POS_W'($urandom_range(shadow_len - 1, 1)),
                                   $urandom);
            endcase
        end
    endtask

    // Refusals on a full list, longest read out, position bounds
    task automatic test_full_list();
        send_item(pol_pkg::F_PUSH, 5'd0, 32'h5555_5555);
        send_item(pol_pkg::F_APPEND, 5'd0, 32'hAAAA_AAAA);
        send_item(pol_pkg::F_INSERT, 5'd1, 32'h0F0F_0F0F);
        send_item(pol_pkg::F_READ, 5'd0, 32'h0);
        send_item(pol_pkg::F_DEL_POS, 5'd16, 32'h0);
        send_item(pol_pkg::F_DEL_POS, 5'd0, 32'h0);
        send_item(pol_pkg::F_DEL_POS, 5'd14, 32'h0);
        send_item(pol_pkg::F_INSERT, 5'd15, 32'h1);
    endtask

    // Random operations, drifting the length between empty and full
    task automatic test_random_mix(input int n);
        int r;
        logic [pol_pkg::FUNC_W-1:0] func;
        logic [pol_pkg::POS_W-1:0]  pos;
        logic [pol_pkg::VAL_W-1:0]  val;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(99);
            if (r < 14) func = pol_pkg::F_PUSH;
            else if (r < 28) func = pol_pkg::F_APPEND;
            else if (r < 44) func = pol_pkg::F_INSERT;
            else if (r < 54) func = pol_pkg::F_DEL_HEAD;
            else if (r < 64) func = pol_pkg::F_DEL_TAIL;
            else if (r < 80) func = pol_pkg::F_DEL_POS;
            else if (r < 97) func = pol_pkg::F_READ;
            else func = F_SPARE;
            // Lean towards shrinking when nearly full
            if (shadow_len >= 14 && func <= pol_pkg::F_INSERT && $urandom_range(1))
                func = pol_pkg::F_DEL_POS;
            if (shadow_len >= 2 && $urandom_range(99) < 75)
                pos = pol_pkg::POS_W'($urandom_range(shadow_len - 1, 1));
            else
                pos = pol_pkg::POS_W'($urandom_range(31));
            case ($urandom_range(19))
                0: val = 32'h8000_0000;
                1: val = 32'h7FFF_FFFF;
                2: val = 32'hFFFF_FFFF;
                3: val = 32'h0000_0000;
                default: val = $urandom;
            endcase
            send_item(func, pos, val);
        end
    endtask

    // Hold off the receiver while items keep coming, so the input stalls
    task automatic test_output_stall();
        @(negedge aclk);
        hold_left = 300;
        test_random_mix(30);
    endtask

    // Receiver: long hold-off when asked, else random idling
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left = hold_left - 1;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Compare each result transfer with the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result transfer, tdata %h tlast %b",
                         $time, m_tdata, m_tlast);
                errors++;
            end else begin
                want = expected_results.pop_front();
                got_status = m_tdata[pol_pkg::M_STAT_LSB +: pol_pkg::STAT_W];
                got_value  = m_tdata[pol_pkg::M_VAL_LSB +: pol_pkg::VAL_W];
                got_length = m_tdata[pol_pkg::M_LEN_LSB +: pol_pkg::LEN_W];
                results_checked++;
                if (got_status !== want.status) begin
                    $display("%0t: status mismatch, expected %0d actual %0d",
                             $time, want.status, got_status);
                    errors++;
                end
                if (got_value !== want.value) begin
                    $display("%0t: result_value mismatch, expected %0d actual %0d",
                             $time, $signed(want.value), $signed(got_value));
                    errors++;
                end
                if (got_length !== want.length) begin
                    $display("%0t: list_length mismatch, expected %0d actual %0d",
                             $time, want.length, got_length);
                    errors++;
                end
                if (m_tlast !== want.last) begin
                    $display("%0t: tlast mismatch, expected %b actual %b",
                             $time, want.last, m_tlast);
                    errors++;
                end
            end
        end
    end

    // Abort a run that hangs
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding",
                     $time, expected_results.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Sender idles a little, receiver a lot
        send_idle_pct = 16;
        recv_idle_pct = 59;
        test_empty_list();
        test_fill_to_capacity();
        test_full_list();
        test_random_mix(80);

        // Sender idles a lot, receiver a little
        send_idle_pct = 59;
        recv_idle_pct = 16;
        test_random_mix(80);

        // Neither side idles, then a long output stall
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_output_stall();
        test_random_mix(10);

        // Drain and let the block settle
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        errors += expected_results.size();

        $display("Ran %0d list operations, checked %0d results (%0d full refusals, %0d range",
                 items_sent, results_checked, full_refusals, range_reports);
        $display("reports) across empty, full, 16-entry read out and a long output stall");
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// File: positional_ordered_list_unit.f
+incdir+src
src/pol_pkg.sv
src/pol_datapath.sv
src/pol_ctrl.sv
src/positional_ordered_list_unit.sv
src/pol_checker.sv
bench/tb.sv
